// ===== rtl/core/pwc_pkg.sv =====
// shared types and geometry functions for the polygon window classifier
package pwc_pkg;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_X_BEGIN = 2'd0;
    localparam logic [1:0] REG_Y_BEGIN = 2'd1;
    localparam logic [1:0] REG_X_END   = 2'd2;
    localparam logic [1:0] REG_Y_END   = 2'd3;

    // relation codes
    localparam logic [1:0] REL_DISJOINT    = 2'd0;
    localparam logic [1:0] REL_CONTAINED   = 2'd1;
    localparam logic [1:0] REL_INTERSECT   = 2'd2;
    localparam logic [1:0] REL_SURROUNDING = 2'd3;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_point;

    // sign of the triangle cross product
    typedef enum logic [1:0] {
        ORI_COL = 2'd0,
        ORI_POS = 2'd1,
        ORI_NEG = 2'd2
    } t_orient;

    typedef struct packed {
        logic hit;
        logic wind_up;
        logic wind_dn;
    } t_edge_res;

    function automatic t_orient orient(t_point p, t_point q, t_point r);
        logic signed [16:0] dqy;
        logic signed [16:0] drx;
        logic signed [16:0] dqx;
        logic signed [16:0] dry;
        logic signed [33:0] m1;
        logic signed [33:0] m2;
        logic signed [34:0] v;
        dqy = 17'(q.y) - 17'(p.y);
        drx = 17'(r.x) - 17'(q.x);
        dqx = 17'(q.x) - 17'(p.x);
        dry = 17'(r.y) - 17'(q.y);
        m1  = dqy * drx;
        m2  = dqx * dry;
        v   = 35'(m1) - 35'(m2);
        if (v == '0) begin
            return ORI_COL;
        end else if (v > 0) begin
            return ORI_POS;
        end else begin
            return ORI_NEG;
        end
    endfunction

    function automatic logic between(logic signed [15:0] a, logic signed [15:0] v,
                                     logic signed [15:0] b);
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (v >= lo) && (v <= hi);
    endfunction

    // q within the bounding box of p and r
    function automatic logic lies_on(t_point p, t_point q, t_point r);
        return between(p.x, q.x, r.x) && between(p.y, q.y, r.y);
    endfunction

endpackage

// ===== rtl/core/polygon_window_classifier.sv =====
// polygon window classifier top level: config port, vertex pipeline, result register
//
// Takes a polygon one vertex per item and, on the item flagged last_vertex,
// returns one relation code for the polygon against the window set in the
// four registers (0 disjoint, 1 contained, 2 intersecting, 3 surrounding).
// Window corners are (x_begin, y_begin) and (x_end - 1, y_end - 1), the
// latter wrapped to 16 bits. Every polygon edge, the closing edge included,
// is tested for inclusive intersection with the four window edges using
// exact 35-bit cross products; the lower corner is checked against the
// polygon by an 8-bit wrapping winding count. Non-last items give no result.
// A vertex is accepted in every cycle in which no result is held on i_stall;
// a last item passes the input register, then the orientation register and
// then the result register, which makes the result valid. The whole pipeline
// holds only while a result waits on i_stall.
// Registers sit at byte addresses 0, 4, 8 and 12 and should be written only
// while no polygon is in flight; reads return the value sign-extended.
module polygon_window_classifier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // vertex items in
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_vertex_x,
    input  logic signed [15:0] i_vertex_y,
    input  logic               i_last_vertex,
    // result items out
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_relation
);

    // window registers
    logic signed [15:0] r_win_x_begin;
    logic signed [15:0] r_win_y_begin;
    logic signed [15:0] r_win_x_end;
    logic signed [15:0] r_win_y_end;

    // polygon tracking at the input side
    logic               r_have_first;
    pwc_pkg::t_point    r_first_v;
    pwc_pkg::t_point    r_prev_v;

    // stage 1: input register
    logic               r_s1_valid;
    logic               r_s1_last;
    logic               r_s1_first;
    pwc_pkg::t_point    r_s1_cur;
    pwc_pkg::t_point    r_s1_prev;
    pwc_pkg::t_point    r_s1_fst;

    // stage 2: orientation register (edge units hold the geometry)
    logic               r_s2_valid;
    logic               r_s2_last;
    logic               r_s2_first;
    logic               r_s2_fin;

    // per-polygon accumulators
    logic               r_edge_hit;
    logic               r_first_in_win;
    logic [7:0]         r_wind;

    // result register
    logic               r_out_valid;
    logic [1:0]         r_relation;

    logic               en;
    logic               accept;
    logic               cfg_wr;
    logic signed [15:0] win_x_last;
    logic signed [15:0] win_y_last;
    pwc_pkg::t_point    corner [4];
    pwc_pkg::t_point    cur_v;
    pwc_pkg::t_edge_res res_step;
    pwc_pkg::t_edge_res res_close;
    logic               use_step;
    logic               use_close;
    logic               n_hit;
    logic               n_fin;
    logic [7:0]         n_wind;
    logic               n_s1_fin;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_x_begin <= 16'sd0;
            r_win_y_begin <= 16'sd0;
            r_win_x_end   <= 16'sd1;
            r_win_y_end   <= 16'sd1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pwc_pkg::REG_X_BEGIN: r_win_x_begin <= pwdata[15:0];
                pwc_pkg::REG_Y_BEGIN: r_win_y_begin <= pwdata[15:0];
                pwc_pkg::REG_X_END:   r_win_x_end   <= pwdata[15:0];
                pwc_pkg::REG_Y_END:   r_win_y_end   <= pwdata[15:0];
                default:              r_win_x_begin <= r_win_x_begin;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pwc_pkg::REG_X_BEGIN: prdata = 32'(r_win_x_begin);
            pwc_pkg::REG_Y_BEGIN: prdata = 32'(r_win_y_begin);
            pwc_pkg::REG_X_END:   prdata = 32'(r_win_x_end);
            pwc_pkg::REG_Y_END:   prdata = 32'(r_win_y_end);
            default:              prdata = '0;
        endcase
    end

    // inclusive far corner, wraps at the 16-bit boundary
    assign win_x_last = r_win_x_end - 16'sd1;
    assign win_y_last = r_win_y_end - 16'sd1;

    // corners walked in order: lower, (x0,y1), far, (x1,y0)
    assign corner[0] = '{x: r_win_x_begin, y: r_win_y_begin};
    assign corner[1] = '{x: r_win_x_begin, y: win_y_last};
    assign corner[2] = '{x: win_x_last,    y: win_y_last};
    assign corner[3] = '{x: win_x_last,    y: r_win_y_begin};

    // ---------------------------------------------------------------- flow
    // everything moves together unless a finished result is being held
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;
    assign accept  = i_valid && en;
    assign cur_v   = '{x: i_vertex_x, y: i_vertex_y};

    // ---------------------------------------------------------------- front
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_s1_valid   <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
            if (accept) begin
                r_have_first <= !i_last_vertex;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_have_first) begin
                r_first_v <= cur_v;
            end
            r_prev_v   <= cur_v;
            r_s1_last  <= i_last_vertex;
            r_s1_first <= !r_have_first;
            r_s1_cur   <= cur_v;
            r_s1_prev  <= r_prev_v;
            // a lone first vertex closes onto itself
            r_s1_fst   <= r_have_first ? r_first_v : cur_v;
        end
    end

    // ---------------------------------------------------------------- stage 2
    // step edge prev->cur and closing edge cur->first
    pwc_edge_test u_edge_step (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_a      (r_s1_prev),
        .i_b      (r_s1_cur),
        .i_corner (corner),
        .o_res    (res_step)
    );

    pwc_edge_test u_edge_close (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_a      (r_s1_cur),
        .i_b      (r_s1_fst),
        .i_corner (corner),
        .o_res    (res_close)
    );

    assign n_s1_fin = (r_s1_cur.x >= r_win_x_begin) && (r_s1_cur.x <= win_x_last) &&
                      (r_s1_cur.y >= r_win_y_begin) && (r_s1_cur.y <= win_y_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_last  <= r_s1_last;
            r_s2_first <= r_s1_first;
            r_s2_fin   <= n_s1_fin;
        end
    end

    // ---------------------------------------------------------------- stage 3
    assign use_step  = !r_s2_first;
    assign use_close = r_s2_last;

    always_comb begin
        n_hit  = r_edge_hit || (use_step && res_step.hit) || (use_close && res_close.hit);
        n_fin  = r_s2_first ? r_s2_fin : r_first_in_win;
        n_wind = r_wind
               + 8'(use_step  && res_step.wind_up)  - 8'(use_step  && res_step.wind_dn)
               + 8'(use_close && res_close.wind_up) - 8'(use_close && res_close.wind_dn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_hit     <= 1'b0;
            r_first_in_win <= 1'b0;
            r_wind         <= '0;
            r_out_valid    <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                if (r_s2_last) begin
                    // polygon closed: report and start afresh
                    r_edge_hit     <= 1'b0;
                    r_first_in_win <= 1'b0;
                    r_wind         <= '0;
                end else begin
                    r_edge_hit     <= n_hit;
                    r_first_in_win <= n_fin;
                    r_wind         <= n_wind;
                end
            end
        end
    end

    // priority: intersecting, contained, surrounding, disjoint
    always_ff @(posedge i_clk) begin
        if (en && r_s2_valid && r_s2_last) begin
            if (n_hit) begin
                r_relation <= pwc_pkg::REL_INTERSECT;
            end else if (n_fin) begin
                r_relation <= pwc_pkg::REL_CONTAINED;
            end else if (n_wind != '0) begin
                r_relation <= pwc_pkg::REL_SURROUNDING;
            end else begin
                r_relation <= pwc_pkg::REL_DISJOINT;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_relation = r_relation;

`ifndef SYNTHESIS
    // a result only ever follows a closing item
    a_result_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && !(r_s2_valid && r_s2_last) |=> !o_valid)
        else $error("result without a last vertex");

    // accumulators are clear once a polygon has been reported
    a_clear_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_s2_valid && r_s2_last |=> (r_wind == '0) && !r_edge_hit)
        else $error("polygon state not cleared after result");

    // accepting a last vertex ends the polygon at the input side
    a_front_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_vertex |=> !r_have_first)
        else $error("first vertex still held after last vertex");

    // a first vertex closes onto itself
    a_first_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_first |-> (r_s1_fst == r_s1_cur))
        else $error("closing edge of first vertex not degenerate");
`endif

endmodule

// ===== rtl/core/pwc_edge_test.sv =====
// one polygon edge against the four window edges, plus its winding contribution
module pwc_edge_test (
    input  logic              i_clk,
    input  logic              i_en,
    input  pwc_pkg::t_point   i_a,
    input  pwc_pkg::t_point   i_b,
    input  pwc_pkg::t_point   i_corner [4],
    output pwc_pkg::t_edge_res o_res
);

    pwc_pkg::t_orient r_opq [4];
    pwc_pkg::t_orient r_ocp [4];
    pwc_pkg::t_orient r_ocq [4];
    logic [3:0]       r_c_on;
    logic [3:0]       r_p_on;
    logic [3:0]       r_q_on;
    logic             r_up_ok;
    logic             r_dn_ok;

    pwc_pkg::t_orient n_opq [4];
    pwc_pkg::t_orient n_ocp [4];
    pwc_pkg::t_orient n_ocq [4];
    logic [3:0]       n_c_on;
    logic [3:0]       n_p_on;
    logic [3:0]       n_q_on;

    // segment under test runs from b to a
    always_comb begin
        logic [1:0] k;
        for (int j = 0; j < 4; j++) begin
            k = 2'(j + 1);
            n_opq[2'(j)]  = pwc_pkg::orient(i_b, i_a, i_corner[2'(j)]);
            n_ocp[2'(j)]  = pwc_pkg::orient(i_corner[2'(j)], i_corner[k], i_b);
            n_ocq[2'(j)]  = pwc_pkg::orient(i_corner[2'(j)], i_corner[k], i_a);
            n_c_on[2'(j)] = pwc_pkg::lies_on(i_b, i_corner[2'(j)], i_a);
            n_p_on[2'(j)] = pwc_pkg::lies_on(i_corner[2'(j)], i_b, i_corner[k]);
            n_q_on[2'(j)] = pwc_pkg::lies_on(i_corner[2'(j)], i_a, i_corner[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_opq   <= n_opq;
            r_ocp   <= n_ocp;
            r_ocq   <= n_ocq;
            r_c_on  <= n_c_on;
            r_p_on  <= n_p_on;
            r_q_on  <= n_q_on;
            r_up_ok <= (i_a.y <= i_corner[0].y) && (i_b.y > i_corner[0].y);
            r_dn_ok <= (i_a.y > i_corner[0].y) && (i_b.y <= i_corner[0].y);
        end
    end

    always_comb begin
        logic [1:0] k;
        logic       hit;
        hit = 1'b0;
        for (int j = 0; j < 4; j++) begin
            k = 2'(j + 1);
            if ((r_opq[2'(j)] != r_opq[k]) && (r_ocp[2'(j)] != r_ocq[2'(j)])) begin
                hit = 1'b1;
            end
            if ((r_opq[2'(j)] == pwc_pkg::ORI_COL) && r_c_on[2'(j)]) begin
                hit = 1'b1;
            end
            if ((r_opq[k] == pwc_pkg::ORI_COL) && r_c_on[k]) begin
                hit = 1'b1;
            end
            if ((r_ocp[2'(j)] == pwc_pkg::ORI_COL) && r_p_on[2'(j)]) begin
                hit = 1'b1;
            end
            if ((r_ocq[2'(j)] == pwc_pkg::ORI_COL) && r_q_on[2'(j)]) begin
                hit = 1'b1;
            end
        end
        o_res.hit = hit;
        // winding cross product of a->b against the lower corner has the sign of
        // the b,a,corner orientation already taken for corner zero
        o_res.wind_up = r_up_ok && (r_opq[0] == pwc_pkg::ORI_POS);
        o_res.wind_dn = r_dn_ok && (r_opq[0] == pwc_pkg::ORI_NEG);
    end

endmodule

// ===== verif/polygon_window_classifier_test.sv =====
// self-checking testbench for the polygon window classifier
module polygon_window_classifier_test;

    localparam int PIPE_DEPTH  = 2;       // last item accepted to result valid
    localparam int CYCLE_LIMIT = 400000;  // watchdog bound on the whole run
    localparam int PHASE_ITEMS = 35;      // random vertices per window setting
    localparam int NUM_PHASES  = 10;

    typedef logic signed [15:0] t_coord;

    typedef struct packed {
        pwc_pkg::t_point pt;
        logic            last;
    } t_vertex_item;

    typedef enum {SHAPE_NEAR, SHAPE_INSIDE, SHAPE_RING, SHAPE_WILD} t_shape_kind;
    typedef enum {STALL_NONE, STALL_RANDOM, STALL_BURSTY} t_stall_style;

    // every input known from time zero
    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [3:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         i_valid       = 1'b0;
    logic         o_stall;
    t_coord       i_vertex_x    = '0;
    t_coord       i_vertex_y    = '0;
    logic         i_last_vertex = 1'b0;
    logic         o_valid;
    logic         i_stall       = 1'b0;
    logic [1:0]   o_relation;

    polygon_window_classifier uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_last_vertex (i_last_vertex),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_relation    (o_relation)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the window registers, reset values
    t_coord win_xb = 16'sd0;
    t_coord win_yb = 16'sd0;
    t_coord win_xe = 16'sd1;
    t_coord win_ye = 16'sd1;

    // predictor copy of the polygon in progress
    pwc_pkg::t_point first_pt     = '0;
    pwc_pkg::t_point prev_pt      = '0;
    bit              poly_started = 1'b0;
    bit              poly_hit     = 1'b0;
    bit              first_inside = 1'b0;
    logic [7:0]      winding      = '0;

    logic [1:0]   expected_relations[$];
    t_vertex_item vertex_q[$];
    int           mismatches = 0;

    // driver and receiver bookkeeping
    t_vertex_item nxt;
    int           burst_left   = 0;
    int           gap_left     = 0;
    t_stall_style stall_style  = STALL_NONE;
    int           stall_hold   = 0;
    int           pattern_tick = 0;
    logic [1:0]   want;

    function automatic int sx(logic [15:0] v);
        return $signed(v);
    endfunction

    // far corner is end minus one, wrapped to 16 bits
    function automatic int corner_hi(t_coord e);
        t_coord c;
        c = e - 16'sd1;
        return sx(c);
    endfunction

    function automatic pwc_pkg::t_orient turn_of(int px, int py, int qx, int qy,
                                                 int rx, int ry);
        longint v;
        v = longint'(qy - py) * longint'(rx - qx) - longint'(qx - px) * longint'(ry - qy);
        if (v == 0) begin
            return pwc_pkg::ORI_COL;
        end
        return (v > 0) ? pwc_pkg::ORI_POS : pwc_pkg::ORI_NEG;
    endfunction

    // q inside the bounding box of p and r
    function automatic bit on_box(int px, int py, int qx, int qy, int rx, int ry);
        return ((qx >= px && qx <= rx) || (qx >= rx && qx <= px)) &&
               ((qy >= py && qy <= ry) || (qy >= ry && qy <= py));
    endfunction

    // inclusive segment test, collinear end points on the other segment count
    function automatic bit segments_touch(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
        pwc_pkg::t_orient o1, o2, o3, o4;
        o1 = turn_of(ax, ay, bx, by, cx, cy);
        o2 = turn_of(ax, ay, bx, by, dx, dy);
        o3 = turn_of(cx, cy, dx, dy, ax, ay);
        o4 = turn_of(cx, cy, dx, dy, bx, by);
        if (o1 != o2 && o3 != o4) begin
            return 1'b1;
        end
        return (o1 == pwc_pkg::ORI_COL && on_box(ax, ay, cx, cy, bx, by)) ||
               (o2 == pwc_pkg::ORI_COL && on_box(ax, ay, dx, dy, bx, by)) ||
               (o3 == pwc_pkg::ORI_COL && on_box(cx, cy, ax, ay, dx, dy)) ||
               (o4 == pwc_pkg::ORI_COL && on_box(cx, cy, bx, by, dx, dy));
    endfunction

    // one polygon edge against the four window edges, then the winding step
    function automatic void trace_edge(int ax, int ay, int bx, int by);
        int     x0, y0, x1, y1, j;
        int     cx[4];
        int     cy[4];
        longint cr;
        x0 = sx(win_xb);
        y0 = sx(win_yb);
        x1 = corner_hi(win_xe);
        y1 = corner_hi(win_ye);
        cx = '{x0, x0, x1, x1};
        cy = '{y0, y1, y1, y0};
        for (j = 0; j < 4; j++) begin
            if (segments_touch(bx, by, ax, ay, cx[j], cy[j], cx[(j + 1) % 4], cy[(j + 1) % 4]))
                poly_hit = 1'b1;
        end
        // lower corner winding: upward crossings with it on the left add, downward ones on the right take
        cr = longint'(bx - ax) * longint'(y0 - ay) - longint'(x0 - ax) * longint'(by - ay);
        if (ay <= y0) begin
            if (by > y0 && cr > 0)
                winding = winding + 8'd1;
        end else if (by <= y0 && cr < 0) begin
            winding = winding - 8'd1;
        end
    endfunction

    // called for every accepted vertex; queues a relation on the closing one
    function automatic void classify_vertex(t_coord x, t_coord y, logic last);
        logic [1:0] rel;
        if (!poly_started) begin
            first_pt     = '{x: x, y: y};
            first_inside = sx(x) >= sx(win_xb) && sx(x) <= corner_hi(win_xe) &&
                           sx(y) >= sx(win_yb) && sx(y) <= corner_hi(win_ye);
            poly_started = 1'b1;
        end else begin
            trace_edge(sx(prev_pt.x), sx(prev_pt.y), sx(x), sx(y));
        end
        prev_pt = '{x: x, y: y};
        if (last) begin
            // closing edge back to the first vertex
            trace_edge(sx(x), sx(y), sx(first_pt.x), sx(first_pt.y));
            if (poly_hit)
                rel = pwc_pkg::REL_INTERSECT;
            else if (first_inside)
                rel = pwc_pkg::REL_CONTAINED;
            else if (winding != 8'd0)
                rel = pwc_pkg::REL_SURROUNDING;
            else
                rel = pwc_pkg::REL_DISJOINT;
            expected_relations.push_back(rel);
            first_pt     = '0;
            prev_pt      = '0;
            poly_started = 1'b0;
            poly_hit     = 1'b0;
            first_inside = 1'b0;
            winding      = '0;
        end
    endfunction

    function automatic int clamp16(int v);
        return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    endfunction

    function automatic int pick(int lo, int hi);
        int a, b;
        a = clamp16((lo < hi) ? lo : hi);
        b = clamp16((lo < hi) ? hi : lo);
        return a + int'($urandom_range(0, b - a));
    endfunction

    // a coordinate around the window span, often right on one of its edges
    function automatic int near_coord(int lo, int hi);
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? lo : hi;
        return pick(lo - 30, hi + 30);
    endfunction

    function automatic void push_vertex(int x, int y, bit last);
        t_vertex_item it;
        it.pt.x = t_coord'(x);
        it.pt.y = t_coord'(y);
        it.last = last;
        vertex_q.push_back(it);
    endfunction

    // one random polygon shaped around the current window, returns its length
    function automatic int add_polygon();
        t_shape_kind shape;
        int          n, r, i, x, y, m;
        int          bx0, bx1, by0, by1, xl, xh, yl, yh;
        int          px[4];
        int          py[4];
        bit          rev;
        x   = corner_hi(win_xe);
        y   = corner_hi(win_ye);
        bx0 = (sx(win_xb) < x) ? sx(win_xb) : x;
        bx1 = (sx(win_xb) < x) ? x : sx(win_xb);
        by0 = (sx(win_yb) < y) ? sx(win_yb) : y;
        by1 = (sx(win_yb) < y) ? y : sx(win_yb);
        r = $urandom_range(0, 99);
        if (r < 40)
            shape = SHAPE_NEAR;
        else if (r < 60)
            shape = SHAPE_INSIDE;
        else if (r < 85)
            shape = SHAPE_RING;
        else
            shape = SHAPE_WILD;

        if (shape == SHAPE_RING) begin
            // ring around the window, a margin of zero grazes it
            m  = $urandom_range(0, 40);
            xl = clamp16(bx0 - m);
            xh = clamp16(bx1 + m);
            yl = clamp16(by0 - m);
            yh = clamp16(by1 + m);
            if ($urandom_range(0, 1)) begin
                px = '{xl, xh, xh, xl};
                py = '{yl, yl, yh, yh};
                n  = 4;
            end else begin
                // right triangle, legs twice the box
                px = '{xl, clamp16(xl + 2 * (xh - xl)), xl, xl};
                py = '{yl, yl, clamp16(yl + 2 * (yh - yl)), yl};
                n  = 3;
            end
            rev = $urandom_range(0, 1);
            for (i = 0; i < n; i++)
                push_vertex(rev ? px[n - 1 - i] : px[i], rev ? py[n - 1 - i] : py[i], i == n - 1);
        end else begin
            // mostly short polygons, a few of 65 to 80 vertices
            r = $urandom_range(0, 99);
            if (r < 5)
                n = $urandom_range(65, 80);
            else if (r < 25)
                n = $urandom_range(7, 20);
            else
                n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
                case (shape)
                    SHAPE_NEAR: begin
                        x = near_coord(bx0, bx1);
                        y = near_coord(by0, by1);
                    end
                    SHAPE_INSIDE: begin
                        x = pick(bx0, bx1);
                        y = pick(by0, by1);
                    end
                    default: begin
                        x = $urandom_range(0, 65535);
                        y = $urandom_range(0, 65535);
                    end
                endcase
                push_vertex(x, y, i == n - 1);
            end
        end
        return n;
    endfunction

    // setup then access; upper data bits are random, only the low half counts
    task automatic write_reg(int idx, int val);
        logic [15:0] upper;
        upper = 16'($urandom_range(0, 65535));
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * idx);
        pwdata  <= {upper, 16'(val)};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pwc_pkg::REG_X_BEGIN: win_xb = t_coord'(val);
            pwc_pkg::REG_Y_BEGIN: win_yb = t_coord'(val);
            pwc_pkg::REG_X_END:   win_xe = t_coord'(val);
            default:              win_ye = t_coord'(val);
        endcase
    endtask

    task automatic set_window(int xb, int yb, int xe, int ye);
        write_reg(pwc_pkg::REG_X_BEGIN, xb);
        write_reg(pwc_pkg::REG_Y_BEGIN, yb);
        write_reg(pwc_pkg::REG_X_END, xe);
        write_reg(pwc_pkg::REG_Y_END, ye);
    endtask

    // small windows mostly, some inverted, some anywhere in the plane
    task automatic random_window();
        int r, xb, yb;
        r  = $urandom_range(0, 3);
        xb = pick(-2000, 2000);
        yb = pick(-2000, 2000);
        if (r < 2)
            set_window(xb, yb, xb + $urandom_range(1, 100), yb + $urandom_range(1, 100));
        else if (r == 2)
            set_window(xb, yb, xb - $urandom_range(0, 50), yb - $urandom_range(0, 50));
        else
            set_window($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    // sampled on the falling edge so the driver and checker have settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (vertex_q.size() != 0 || i_valid || expected_relations.size() != 0);
    endtask

    // vertex driver: bursts of random length, random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                classify_vertex(i_vertex_x, i_vertex_y, i_last_vertex);
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (vertex_q.size() != 0) begin
                    nxt = vertex_q.pop_front();
                    i_vertex_x    <= nxt.pt.x;
                    i_vertex_y    <= nxt.pt.y;
                    i_last_vertex <= nxt.last;
                    i_valid       <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result checker and receiver stall, the stall style is redrawn when its hold count runs out
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_relations.size() == 0) begin
                    $error("relation: expected none, got %0d", o_relation);
                    mismatches++;
                end else begin
                    want = expected_relations.pop_front();
                    if (o_relation !== want) begin
                        $error("relation: expected %0d, got %0d", want, o_relation);
                        mismatches++;
                    end
                end
            end
            if (stall_hold == 0) begin
                stall_style <= t_stall_style'($urandom_range(0, 2));
                stall_hold  <= $urandom_range(16, 96);
            end else begin
                stall_hold <= stall_hold - 1;
            end
            pattern_tick <= pattern_tick + 1;
            case (stall_style)
                STALL_NONE:   i_stall <= 1'b0;
                STALL_RANDOM: i_stall <= ($urandom_range(0, 2) == 0);
                default:      i_stall <= (pattern_tick % 13) < 9;
            endcase
        end
    end

    initial begin : stimulus
        int phase, got, loop;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // reset window is the single pixel at the origin, a vertex on it
        push_vertex(0, 0, 1'b1);
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                wait_drained();
                repeat (PIPE_DEPTH + 2) @(posedge i_clk);
                case (phase)
                    1:       set_window(10, 10, 20, 20);
                    // end of -32768 wraps the far corner to 32767: the whole plane
                    2:       set_window(-32768, -32768, -32768, -32768);
                    // inverted extremes, nothing can be contained
                    3:       set_window(32767, 32767, -32767, -32767);
                    4:       set_window(100, 100, 110, 110);
                    default: random_window();
                endcase
                @(negedge i_clk);
            end
            if (phase == 1) begin
                // single vertex inside, then outside
                push_vertex(15, 15, 1'b1);
                push_vertex(0, 0, 1'b1);
                // two vertices across the window, closing edge runs back over it
                push_vertex(0, 15, 1'b0);
                push_vertex(30, 15, 1'b1);
                // triangle around the window, both windings
                push_vertex(-100, -100, 1'b0);
                push_vertex(100, -100, 1'b0);
                push_vertex(0, 100, 1'b1);
                push_vertex(0, 100, 1'b0);
                push_vertex(100, -100, 1'b0);
                push_vertex(-100, -100, 1'b1);
                // collinear edge ending on the window corner
                push_vertex(5, 10, 1'b0);
                push_vertex(10, 10, 1'b1);
                // repeated vertex gives a zero length edge
                push_vertex(50, 50, 1'b0);
                push_vertex(50, 50, 1'b0);
                push_vertex(60, 60, 1'b1);
                // extremes of both coordinates
                push_vertex(-32768, -32768, 1'b0);
                push_vertex(32767, -32768, 1'b0);
                push_vertex(32767, 32767, 1'b0);
                push_vertex(-32768, 32767, 1'b1);
            end
            if (phase == 4) begin
                // four turns round the window: the winding count builds up past one
                for (loop = 0; loop < 4; loop++) begin
                    push_vertex(95, 95, 1'b0);
                    push_vertex(133, 95, 1'b0);
                    push_vertex(95, 133, loop == 3);
                end
            end
            got = 0;
            while (got < PHASE_ITEMS)
                got += add_polygon();
        end
        wait_drained();
        repeat (PIPE_DEPTH * 4) @(posedge i_clk);
        if (mismatches == 0)
            $display("polygon_window_classifier_test: done, clean");
        else
            $display("polygon_window_classifier_test: done, errors");
        $finish;
    end

    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge i_clk);
        $display("polygon_window_classifier_test: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pwc_pkg.sv
rtl/core/pwc_edge_test.sv
rtl/core/polygon_window_classifier.sv
verif/polygon_window_classifier_test.sv
